// ===== rtl/tts_pkg.sv =====
package tts_pkg;

    // Counter and tick widths inside the block
    localparam int COUNTER_BITS    = 64;
    localparam int TICK_COUNT_BITS = 32;
    localparam int PERIOD_W        = 16;

    // Port field widths
    localparam int OPC_W       = 3;
    localparam int CNT_PORT_W  = 64;
    localparam int TICK_PORT_W = 32;

    // Divider retires two quotient bits per step
    localparam int DIV_STEPS = (COUNTER_BITS + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int PROD_W    = TICK_COUNT_BITS + PERIOD_W;
    localparam int SUM_W     = (COUNTER_BITS > PROD_W) ? COUNTER_BITS : PROD_W;

    localparam int PC_W = 4;

    localparam logic [OPC_W-1:0] OP_START = 3'd0;
    localparam logic [OPC_W-1:0] OP_TICK  = 3'd1;
    localparam logic [OPC_W-1:0] OP_SLEEP = 3'd2;
    localparam logic [OPC_W-1:0] OP_WAKE  = 3'd3;
    localparam logic [OPC_W-1:0] OP_READ  = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Microprogram addresses
    localparam logic [PC_W-1:0] A_START     = 4'd0;
    localparam logic [PC_W-1:0] A_TICK      = 4'd1;
    localparam logic [PC_W-1:0] A_SLP_MUL   = 4'd2;
    localparam logic [PC_W-1:0] A_SLP_OUT   = 4'd3;
    localparam logic [PC_W-1:0] A_WAKE_INIT = 4'd4;
    localparam logic [PC_W-1:0] A_DIV_STEP  = 4'd5;
    localparam logic [PC_W-1:0] A_CLAMP     = 4'd6;
    localparam logic [PC_W-1:0] A_DONE_ZERO = 4'd7;
    localparam logic [PC_W-1:0] A_WAKE_MUL  = 4'd8;
    localparam logic [PC_W-1:0] A_WAKE_ADD  = 4'd9;
    localparam logic [PC_W-1:0] A_WAKE_OUT  = 4'd10;
    localparam logic [PC_W-1:0] A_READ      = 4'd11;
    localparam logic [PC_W-1:0] A_NOP       = 4'd12;

    typedef enum logic [3:0] {
        U_START,
        U_TICK,
        U_SLP_MUL,
        U_SLP_OUT,
        U_WAKE_INIT,
        U_DIV_STEP,
        U_CLAMP,
        U_DONE_ZERO,
        U_WAKE_MUL,
        U_WAKE_ADD,
        U_WAKE_OUT,
        U_READ,
        U_NOP
    } uop_t;

    typedef enum logic [1:0] {
        C_NONE,
        C_ALWAYS,
        C_LT,
        C_DIV_MORE
    } cond_t;

    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } ucw_t;

    typedef struct packed {
        logic now_lt_grid;
        logic div_more;
    } dp_stat_t;

    function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
        ucw_t w;
        begin
            w = '{uop: U_NOP, cond: C_NONE, target: A_NOP, last: 1'b1};
            case (pc)
                A_START:     w = '{U_START,     C_NONE,     A_START,     1'b1};
                A_TICK:      w = '{U_TICK,      C_NONE,     A_TICK,      1'b1};
                A_SLP_MUL:   w = '{U_SLP_MUL,   C_NONE,     A_SLP_MUL,   1'b0};
                A_SLP_OUT:   w = '{U_SLP_OUT,   C_NONE,     A_SLP_OUT,   1'b1};
                A_WAKE_INIT: w = '{U_WAKE_INIT, C_LT,       A_DONE_ZERO, 1'b0};
                A_DIV_STEP:  w = '{U_DIV_STEP,  C_DIV_MORE, A_DIV_STEP,  1'b0};
                A_CLAMP:     w = '{U_CLAMP,     C_ALWAYS,   A_WAKE_MUL,  1'b0};
                A_DONE_ZERO: w = '{U_DONE_ZERO, C_NONE,     A_DONE_ZERO, 1'b0};
                A_WAKE_MUL:  w = '{U_WAKE_MUL,  C_NONE,     A_WAKE_MUL,  1'b0};
                A_WAKE_ADD:  w = '{U_WAKE_ADD,  C_NONE,     A_WAKE_ADD,  1'b0};
                A_WAKE_OUT:  w = '{U_WAKE_OUT,  C_NONE,     A_WAKE_OUT,  1'b1};
                A_READ:      w = '{U_READ,      C_NONE,     A_READ,      1'b1};
                A_NOP:       w = '{U_NOP,       C_NONE,     A_NOP,       1'b1};
                default:     w = '{U_NOP,       C_NONE,     A_NOP,       1'b1};
            endcase
            return w;
        end
    endfunction

    function automatic logic [PC_W-1:0] entry_of(input logic [OPC_W-1:0] op);
        logic [PC_W-1:0] a;
        begin
            case (op)
                OP_START: a = A_START;
                OP_TICK:  a = A_TICK;
                OP_SLEEP: a = A_SLP_MUL;
                OP_WAKE:  a = A_WAKE_INIT;
                OP_READ:  a = A_READ;
                default:  a = A_NOP;
            endcase
            return a;
        end
    endfunction

endpackage

// ===== rtl/tts_if.sv =====
interface tts_evt_if import tts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OPC_W-1:0]       opcode;
    logic [CNT_PORT_W-1:0]  counter_now;
    logic [TICK_PORT_W-1:0] idle_ticks;

    modport source(output valid, opcode, counter_now, idle_ticks, input ready);
    modport sink(input valid, opcode, counter_now, idle_ticks, output ready);
endinterface

interface tts_res_if import tts_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CNT_PORT_W-1:0]  compare_value;
    logic [TICK_PORT_W-1:0] step_ticks;
    logic [CNT_PORT_W-1:0]  elapsed_count;

    modport source(output valid, compare_value, step_ticks, elapsed_count, input ready);
    modport sink(input valid, compare_value, step_ticks, elapsed_count, output ready);
endinterface

// ===== rtl/tts_seq.sv =====
module tts_seq import tts_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OPC_W-1:0] opcode,
    input  logic             adv,
    input  dp_stat_t         stat,
    output ucw_t             cw,
    output logic             busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            busy_reg;
    logic            busy_next;
    logic            taken;

    assign cw   = ucode(pc_reg);
    assign busy = busy_reg;

    always_comb
    begin
        case (cw.cond)
            C_NONE:     taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_LT:       taken = stat.now_lt_grid;
            C_DIV_MORE: taken = stat.div_more;
            default:    taken = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                pc_next   = entry_of(opcode);
                busy_next = 1'b1;
            end
        end
        else if (adv)
        begin
            if (cw.last)
                busy_next = 1'b0;
            else if (taken)
                pc_next = cw.target;
            else
                pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= A_NOP;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== rtl/tickless_tick_compare_scheduler.sv =====
// Each input beat runs a microprogram: start, tick, read time and unused codes end at
// their entry word; a sleep request multiplies, then outputs; a wake inits, divides by
// the tick period (two quotient bits per cycle, 32 steps for a 64-bit counter), clamps,
// multiplies, adds and outputs (no divide or clamp if it is before the grid point).
// A new event is taken only once the sequence ends. Reset (rst_n, asynchronous, active
// low) zeroes grid state and divider count, sets cycles_per_tick to 1000; then ready.
module tickless_tick_compare_scheduler import tts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    tts_evt_if.sink             evt,
    tts_res_if.source           res,
    input  logic                cfg_we,
    input  logic [PERIOD_W-1:0] cfg_data
);

    localparam int CW = COUNTER_BITS;
    localparam int TW = TICK_COUNT_BITS;

    ucw_t     cw;
    dp_stat_t stat;
    logic     busy;
    logic     adv;
    logic     out_load;
    logic     evt_accept;

    logic [PERIOD_W-1:0] per_cfg_reg;
    logic [PERIOD_W-1:0] per_eff;

    logic [OPC_W-1:0]  opc_reg;
    logic [CW-1:0]     now_reg;
    logic [TW-1:0]     idle_reg;

    logic [CW-1:0]        nc_reg,    nc_next;
    logic [CW-1:0]        grid_reg,  grid_pt_next;
    logic [TW-1:0]        sl_reg,    sl_next;
    logic [CW-1:0]        base_reg,  base_next;
    logic [PROD_W-1:0]    prod_reg,  prod_next;
    logic [DIV_W-1:0]     quo_reg,   quo_next;
    logic [PERIOD_W-1:0]  rem_reg,   rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [TW-1:0]        done_reg,  done_next;
    logic [CW-1:0]        acc_reg,   acc_next;

    logic          res_valid_reg, res_valid_next;
    logic [CW-1:0] out_cmp_reg,   out_cmp_next;
    logic [TW-1:0] out_step_reg,  out_step_next;
    logic [CW-1:0] out_el_reg,    out_el_next;

    logic [TW-1:0]       idle_sat;
    logic [CW-1:0]       now_plus_per;
    logic [SUM_W-1:0]    grid_sum;
    logic [PERIOD_W:0]   ra, rb, ra_sub, rb_sub;
    logic                qa, qb;
    logic [PERIOD_W-1:0] rem_mid;

    assign per_eff      = (per_cfg_reg == '0) ? PERIOD_W'(1) : per_cfg_reg;
    assign evt.ready    = !busy;
    assign evt_accept   = evt.valid && !busy;
    // Hold the final step while the previous result still waits
    assign adv          = busy && !(cw.last && res_valid_reg && !res.ready);
    assign out_load     = adv && cw.last;

    assign stat.now_lt_grid = now_reg < grid_reg;
    assign stat.div_more    = div_cnt_reg != DIV_CNT_W'(DIV_STEPS - 1);

    assign idle_sat     = (idle_reg == '0) ? TW'(1) : idle_reg;
    assign now_plus_per = now_reg + CW'(per_eff);
    assign grid_sum     = SUM_W'(grid_reg) + SUM_W'(prod_reg);

    // Two restoring divide steps per cycle
    assign ra      = {rem_reg, quo_reg[DIV_W-1]};
    assign ra_sub  = ra - {1'b0, per_eff};
    assign qa      = ra >= {1'b0, per_eff};
    assign rem_mid = qa ? ra_sub[PERIOD_W-1:0] : ra[PERIOD_W-1:0];
    assign rb      = {rem_mid, quo_reg[DIV_W-2]};
    assign rb_sub  = rb - {1'b0, per_eff};
    assign qb      = rb >= {1'b0, per_eff};

    tts_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (evt_accept),
        .opcode (evt.opcode),
        .adv    (adv),
        .stat   (stat),
        .cw     (cw),
        .busy   (busy)
    );

    always_comb
    begin
        nc_next       = nc_reg;
        grid_pt_next  = grid_reg;
        sl_next       = sl_reg;
        base_next     = base_reg;
        prod_next     = prod_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        done_next     = done_reg;
        acc_next      = acc_reg;
        out_cmp_next  = out_cmp_reg;
        out_step_next = out_step_reg;
        out_el_next   = out_el_reg;
        if (adv)
        begin
            case (cw.uop)
                U_START:
                begin
                    base_next     = now_reg;
                    nc_next       = now_plus_per;
                    out_cmp_next  = now_plus_per;
                    out_step_next = '0;
                    out_el_next   = '0;
                end
                U_TICK:
                begin
                    nc_next       = nc_reg + CW'(per_eff);
                    out_cmp_next  = nc_reg + CW'(per_eff);
                    out_step_next = TW'(1);
                    out_el_next   = '0;
                end
                U_SLP_MUL:
                begin
                    sl_next      = idle_sat;
                    grid_pt_next = nc_reg;
                    prod_next    = PROD_W'(idle_sat - TW'(1)) * PROD_W'(per_eff);
                end
                U_SLP_OUT:
                begin
                    out_cmp_next  = grid_sum[CW-1:0];
                    out_step_next = '0;
                    out_el_next   = '0;
                end
                U_WAKE_INIT:
                begin
                    quo_next     = DIV_W'(now_reg - grid_reg);
                    rem_next     = '0;
                    div_cnt_next = '0;
                end
                U_DIV_STEP:
                begin
                    quo_next     = {quo_reg[DIV_W-3:0], qa, qb};
                    rem_next     = qb ? rb_sub[PERIOD_W-1:0] : rb[PERIOD_W-1:0];
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
                U_CLAMP:
                begin
                    // Clamp passed grid points to the idle length
                    if (quo_reg >= DIV_W'(sl_reg))
                        done_next = sl_reg;
                    else
                        done_next = quo_reg[TW-1:0] + TW'(1);
                end
                U_DONE_ZERO:
                begin
                    done_next = '0;
                end
                U_WAKE_MUL:
                begin
                    prod_next = PROD_W'(done_reg) * PROD_W'(per_eff);
                end
                U_WAKE_ADD:
                begin
                    acc_next = grid_sum[CW-1:0];
                end
                U_WAKE_OUT:
                begin
                    // Grid point already past: re-arm one period after wake
                    if (acc_reg <= now_reg)
                    begin
                        nc_next      = now_plus_per;
                        out_cmp_next = now_plus_per;
                    end
                    else
                    begin
                        nc_next      = acc_reg;
                        out_cmp_next = acc_reg;
                    end
                    out_step_next = done_reg;
                    out_el_next   = '0;
                end
                U_READ:
                begin
                    out_cmp_next  = nc_reg;
                    out_step_next = '0;
                    out_el_next   = now_reg - base_reg;
                end
                U_NOP:
                begin
                    out_cmp_next  = nc_reg;
                    out_step_next = '0;
                    out_el_next   = '0;
                end
                default:
                begin
                    out_cmp_next = nc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_load)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_cfg_reg   <= PERIOD_RESET;
            nc_reg        <= '0;
            grid_reg      <= '0;
            sl_reg        <= '0;
            base_reg      <= '0;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                per_cfg_reg <= cfg_data;
            nc_reg        <= nc_next;
            grid_reg      <= grid_pt_next;
            sl_reg        <= sl_next;
            base_reg      <= base_next;
            div_cnt_reg   <= div_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            opc_reg  <= evt.opcode;
            now_reg  <= evt.counter_now[CW-1:0];
            idle_reg <= evt.idle_ticks[TW-1:0];
        end
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        done_reg     <= done_next;
        acc_reg      <= acc_next;
        out_cmp_reg  <= out_cmp_next;
        out_step_reg <= out_step_next;
        out_el_reg   <= out_el_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.compare_value = CNT_PORT_W'(out_cmp_reg);
    assign res.step_ticks    = TICK_PORT_W'(out_step_reg);
    assign res.elapsed_count = CNT_PORT_W'(out_el_reg);

    property p_result_from_sequence;
        @(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(busy);
    endproperty
    a_result_from_sequence: assert property (p_result_from_sequence)
        else $error("result appeared without an active sequence");

    property p_div_only_busy;
        @(posedge clk) disable iff (!rst_n)
        (div_cnt_reg != $past(div_cnt_reg)) |-> $past(busy);
    endproperty
    a_div_only_busy: assert property (p_div_only_busy)
        else $error("divider counter moved while idle");

    property p_wake_clamped;
        @(posedge clk) disable iff (!rst_n)
        (out_load && opc_reg == OP_WAKE) |=> (out_step_reg <= sl_reg);
    endproperty
    a_wake_clamped: assert property (p_wake_clamped)
        else $error("wake reported more ticks than the idle length");

endmodule
